/* sv/pas_pkg.sv */
// ----------------------------------------------------------------------------
// Pool address sequencer package
// Shared types, register codes and sizing constants.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int WARMUP_ROWS_DEF = 64;
  localparam int TIMER_W         = 7;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_X_STRIDE = 3'd0,
    CFG_SRC_Y_STRIDE = 3'd1,
    CFG_SRC_Z_STRIDE = 3'd2,
    CFG_SRC_X_LIMIT  = 3'd3,
    CFG_SRC_Y_LIMIT  = 3'd4,
    CFG_SRC_Z_LIMIT  = 3'd5,
    CFG_DST_X_STRIDE = 3'd6,
    CFG_DST_Y_STRIDE = 3'd7
  } cfg_reg_t;

  typedef enum logic [0:0] {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SCALE
  } eng_state_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] src_base;
    logic [31:0] dst_base;
    logic [7:0]  dst_x_extent;
    logic [7:0]  dst_y_extent;
    logic        pool_ident;
    logic [3:0]  elem_size;
  } in_req_t;

  typedef struct packed {
    logic        out_valid;
    logic        pool_start;
    logic        pool_stop;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        busy_res;
  } out_res_t;

  typedef struct packed {
    req_kind_t kind;
    in_req_t   req;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] src_x_stride;
    logic [15:0] src_y_stride;
    logic [15:0] src_z_stride;
    logic [7:0]  src_x_count_limit;
    logic [7:0]  src_y_count_limit;
    logic [7:0]  src_z_count_limit;
    logic [15:0] dst_x_stride;
    logic [15:0] dst_y_stride;
  } cfg_t;

endpackage

/* sv/pas_front.sv */
// ----------------------------------------------------------------------------
// Pool address sequencer front end
// Accepts requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module pas_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pas_pkg::in_req_t  in_data,
  output logic              q_valid,
  output pas_pkg::q_entry_t q_head,
  input  logic              q_pop
);

  localparam int DEPTH = pas_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pas_pkg::q_entry_t mem [DEPTH];
  pas_pkg::q_entry_t entry_in;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign in_ready = (count_r != CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    entry_in.kind = pas_pkg::req_kind_t'(in_data.req_type);
    entry_in.req  = in_data;
  end

  assign q_head = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= entry_in;
    end
  end

endmodule

/* sv/pas_engine.sv */
// ----------------------------------------------------------------------------
// Pool address sequencer engine
// Steps the counters, computes byte addresses and holds the result register.
// ----------------------------------------------------------------------------
module pas_engine #(
  parameter int WARMUP_ROWS = pas_pkg::WARMUP_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pas_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  pas_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pas_pkg::out_res_t out_data
);

  localparam int TW = pas_pkg::TIMER_W;

  pas_pkg::eng_state_t state_r, state_nxt;

  logic          busy_r, busy_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic          valid_r, valid_nxt;
  logic          start_r, start_nxt;
  logic          stop_r, stop_nxt;
  logic [7:0]    sx_r, sx_nxt;
  logic [7:0]    sy_r, sy_nxt;
  logic [7:0]    sz_r, sz_nxt;
  logic [7:0]    dx_r, dx_nxt;
  logic [7:0]    dy_r, dy_nxt;
  logic [31:0]   src_addr_r, src_addr_nxt;
  logic [31:0]   dst_addr_r, dst_addr_nxt;
  logic [31:0]   src_base_r, src_base_nxt;
  logic [31:0]   dst_base_r, dst_base_nxt;
  logic [7:0]    dxl_r, dxl_nxt;
  logic [7:0]    dyl_r, dyl_nxt;
  logic          ident_r, ident_nxt;
  logic [3:0]    elem_r, elem_nxt;
  logic          usrc_r, usrc_nxt;
  logic          udst_r, udst_nxt;
  logic          win_end;

  logic [23:0]   psx_r, psy_r, psz_r, pdx_r, pdy_r;
  logic [25:0]   ssum_r;
  logic [24:0]   dsum_r;
  logic [31:0]   src_calc;
  logic [31:0]   dst_calc;

  logic              out_vld_r;
  pas_pkg::out_res_t out_r;
  logic              out_free;
  logic              apply;
  logic              out_load;

  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pas_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = pas_pkg::ST_MUL;
        end
      end
      pas_pkg::ST_MUL:   state_nxt = pas_pkg::ST_SUM;
      pas_pkg::ST_SUM:   state_nxt = pas_pkg::ST_SCALE;
      pas_pkg::ST_SCALE: begin
        if (out_free) begin
          state_nxt = pas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    apply    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      pas_pkg::ST_IDLE:  apply    = q_valid;
      pas_pkg::ST_SCALE: out_load = out_free;
      default: begin
        apply    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign q_pop = apply;

  always_comb begin
    busy_nxt     = busy_r;
    timer_nxt    = timer_r;
    valid_nxt    = valid_r;
    start_nxt    = start_r;
    stop_nxt     = stop_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    sz_nxt       = sz_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    src_addr_nxt = src_addr_r;
    dst_addr_nxt = dst_addr_r;
    src_base_nxt = src_base_r;
    dst_base_nxt = dst_base_r;
    dxl_nxt      = dxl_r;
    dyl_nxt      = dyl_r;
    ident_nxt    = ident_r;
    elem_nxt     = elem_r;
    usrc_nxt     = 1'b0;
    udst_nxt     = 1'b0;
    win_end      = 1'b0;
    if (q_head.kind == pas_pkg::REQ_START) begin
      if (!busy_r) begin
        busy_nxt     = 1'b1;
        timer_nxt    = TW'(WARMUP_ROWS);
        ident_nxt    = q_head.req.pool_ident;
        elem_nxt     = q_head.req.elem_size;
        src_base_nxt = q_head.req.src_base;
        dst_base_nxt = q_head.req.dst_base;
        src_addr_nxt = q_head.req.src_base;
        dst_addr_nxt = q_head.req.dst_base;
        dxl_nxt      = q_head.req.dst_x_extent;
        dyl_nxt      = q_head.req.dst_y_extent;
        start_nxt    = 1'b1;
        stop_nxt     = q_head.req.pool_ident ||
                       (({1'b0, cfg.src_x_count_limit} + {1'b0, cfg.src_y_count_limit})
                        == 9'd2);
        sx_nxt       = '0;
        sy_nxt       = '0;
        sz_nxt       = '0;
        dx_nxt       = '0;
        dy_nxt       = '0;
      end
    end else if (busy_r) begin
      if (timer_r != '0) begin
        timer_nxt = timer_r - 1'b1;
        if (timer_nxt == '0) begin
          valid_nxt = 1'b1;
        end
      end else if (valid_r) begin
        sx_nxt = sx_r + 8'd1;
        if (sx_nxt >= cfg.src_x_count_limit) begin
          sx_nxt = '0;
          sy_nxt = sy_r + 8'd1;
        end
        if (sy_nxt >= cfg.src_y_count_limit) begin
          sy_nxt = '0;
          sz_nxt = sz_r + 8'd1;
        end
        if (sz_nxt >= cfg.src_z_count_limit) begin
          sz_nxt = '0;
        end
        win_end = (({1'b0, sx_nxt} + 9'd1) == {1'b0, cfg.src_x_count_limit}) &&
                  (({1'b0, sy_nxt} + 9'd1) == {1'b0, cfg.src_y_count_limit}) &&
                  (({1'b0, sz_nxt} + 9'd1) == {1'b0, cfg.src_z_count_limit});
        if (ident_r || win_end) begin
          dx_nxt = dx_r + 8'd1;
          if (dx_nxt >= dxl_r) begin
            dx_nxt = '0;
            dy_nxt = dy_r + 8'd1;
          end
        end
        if (ident_r) begin
          start_nxt = 1'b1;
          stop_nxt  = 1'b1;
        end else begin
          start_nxt = stop_r;
          stop_nxt  = win_end;
        end
        if (dy_nxt >= dyl_r) begin
          dy_nxt    = '0;
          valid_nxt = 1'b0;
          busy_nxt  = 1'b0;
        end
        usrc_nxt = valid_nxt;
        udst_nxt = start_nxt;
      end
    end
  end

  assign src_calc = src_base_r + ({6'd0, ssum_r} * {28'd0, elem_r});
  assign dst_calc = dst_base_r + ({7'd0, dsum_r} * {28'd0, elem_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pas_pkg::ST_IDLE;
      busy_r     <= 1'b0;
      timer_r    <= '0;
      valid_r    <= 1'b0;
      start_r    <= 1'b0;
      stop_r     <= 1'b0;
      sx_r       <= '0;
      sy_r       <= '0;
      sz_r       <= '0;
      dx_r       <= '0;
      dy_r       <= '0;
      src_addr_r <= '0;
      dst_addr_r <= '0;
      src_base_r <= '0;
      dst_base_r <= '0;
      dxl_r      <= 8'd1;
      dyl_r      <= 8'd1;
      ident_r    <= 1'b0;
      elem_r     <= 4'd1;
      usrc_r     <= 1'b0;
      udst_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply) begin
        busy_r     <= busy_nxt;
        timer_r    <= timer_nxt;
        valid_r    <= valid_nxt;
        start_r    <= start_nxt;
        stop_r     <= stop_nxt;
        sx_r       <= sx_nxt;
        sy_r       <= sy_nxt;
        sz_r       <= sz_nxt;
        dx_r       <= dx_nxt;
        dy_r       <= dy_nxt;
        src_addr_r <= src_addr_nxt;
        dst_addr_r <= dst_addr_nxt;
        src_base_r <= src_base_nxt;
        dst_base_r <= dst_base_nxt;
        dxl_r      <= dxl_nxt;
        dyl_r      <= dyl_nxt;
        ident_r    <= ident_nxt;
        elem_r     <= elem_nxt;
        usrc_r     <= usrc_nxt;
        udst_r     <= udst_nxt;
      end
      if (out_load) begin
        if (usrc_r) begin
          src_addr_r <= src_calc;
        end
        if (udst_r) begin
          dst_addr_r <= dst_calc;
        end
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pas_pkg::ST_MUL) begin
      psx_r <= 24'(sx_r) * 24'(cfg.src_x_stride);
      psy_r <= 24'(sy_r) * 24'(cfg.src_y_stride);
      psz_r <= 24'(sz_r) * 24'(cfg.src_z_stride);
      pdx_r <= 24'(dx_r) * 24'(cfg.dst_x_stride);
      pdy_r <= 24'(dy_r) * 24'(cfg.dst_y_stride);
    end
    if (state_r == pas_pkg::ST_SUM) begin
      ssum_r <= 26'(psx_r) + 26'(psy_r) + 26'(psz_r);
      dsum_r <= 25'(pdx_r) + 25'(pdy_r);
    end
    if (out_load) begin
      out_r.out_valid  <= valid_r;
      out_r.pool_start <= start_r;
      out_r.pool_stop  <= stop_r;
      out_r.src_addr   <= usrc_r ? src_calc : src_addr_r;
      out_r.dst_addr   <= udst_r ? dst_calc : dst_addr_r;
      out_r.busy_res   <= busy_r;
    end
  end

endmodule

/* sv/pool_address_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Pool address sequencer top level
// 3D strided source and 2D destination address generator for pooling.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request channel. req_type 1 starts a pool operation
//           (ignored while busy), req_type 0 is a clock tick.
//   out_* : valid/ready result channel, exactly one result per request,
//           showing flags and byte addresses after that request.
//   cfg_* : write-only register port; write strides and limits while idle.
//   Each request passes through the engine in order: it updates the
//   counters, does the stride multiplies, forms the sums, then scales by
//   the element size and loads the result register. The engine takes the
//   next request from the queue only after loading the result of the last.
//   A two-entry request queue buffers requests while the engine works;
//   a stalled receiver holds the result register and the engine waits in
//   its last step, after which the queue fills and in_ready drops.
//   Synchronous reset clears the queue, the result valid flag and all
//   counters, and sets every configuration register to 1.
// ----------------------------------------------------------------------------
module pool_address_sequencer_top #(
  parameter int WARMUP_ROWS = pas_pkg::WARMUP_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pas_pkg::in_req_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pas_pkg::out_res_t                out_data,
  input  logic                             cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pas_pkg::cfg_t     cfg_r;
  logic              q_valid;
  logic              q_pop;
  pas_pkg::q_entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_x_stride      <= 16'd1;
      cfg_r.src_y_stride      <= 16'd1;
      cfg_r.src_z_stride      <= 16'd1;
      cfg_r.src_x_count_limit <= 8'd1;
      cfg_r.src_y_count_limit <= 8'd1;
      cfg_r.src_z_count_limit <= 8'd1;
      cfg_r.dst_x_stride      <= 16'd1;
      cfg_r.dst_y_stride      <= 16'd1;
    end else if (cfg_we) begin
      case (pas_pkg::cfg_reg_t'(cfg_index))
        pas_pkg::CFG_SRC_X_STRIDE: cfg_r.src_x_stride      <= cfg_wdata;
        pas_pkg::CFG_SRC_Y_STRIDE: cfg_r.src_y_stride      <= cfg_wdata;
        pas_pkg::CFG_SRC_Z_STRIDE: cfg_r.src_z_stride      <= cfg_wdata;
        pas_pkg::CFG_SRC_X_LIMIT:  cfg_r.src_x_count_limit <= cfg_wdata[7:0];
        pas_pkg::CFG_SRC_Y_LIMIT:  cfg_r.src_y_count_limit <= cfg_wdata[7:0];
        pas_pkg::CFG_SRC_Z_LIMIT:  cfg_r.src_z_count_limit <= cfg_wdata[7:0];
        pas_pkg::CFG_DST_X_STRIDE: cfg_r.dst_x_stride      <= cfg_wdata;
        pas_pkg::CFG_DST_Y_STRIDE: cfg_r.dst_y_stride      <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  pas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  pas_engine #(
    .WARMUP_ROWS (WARMUP_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* dv/pas_addr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool address sequencer checker
// Watches the request, result and register ports, keeps a cycle-free model
// of the sequencer's counters, strobes and byte addresses, and compares every
// result with the prediction made when its request was accepted.
// ----------------------------------------------------------------------------
module pas_addr_checker #(
  parameter int WARMUP = pas_pkg::WARMUP_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  pas_pkg::in_req_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  pas_pkg::out_res_t              out_data,
  input  logic                           cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending,
  output logic                           pool_active
);
  import pas_pkg::*;

  localparam logic [TIMER_W-1:0] WARM_LOAD = TIMER_W'(WARMUP);

  logic [15:0]        x_step, y_step, z_step, dx_step, dy_step;
  logic [7:0]         x_lim, y_lim, z_lim;
  logic               running, addr_live, win_start, win_stop, ident;
  logic [TIMER_W-1:0] warm_left;
  logic [7:0]         sx, sy, sz, dx, dy, dx_lim, dy_lim;
  logic [31:0]        src_addr, dst_addr, src_base, dst_base;
  logic [3:0]         elem_bytes;
  out_res_t           addr_expect_q[$];
  int                 reported = 0;

  initial begin
    errors      = 0;
    pending     = 0;
    pool_active = 1'b0;
  end

  always @(posedge clk) begin : track
    logic        wend;
    logic        prev_stop;
    logic [31:0] px, py, pz, kx, ky, kz, pdx, pdy, kdx, kdy, pe;
    out_res_t    got, want;
    if (!rst_n) begin
      x_step = 16'd1; y_step = 16'd1; z_step = 16'd1;
      dx_step = 16'd1; dy_step = 16'd1;
      x_lim = 8'd1; y_lim = 8'd1; z_lim = 8'd1;
      running = 1'b0; addr_live = 1'b0; win_start = 1'b0; win_stop = 1'b0;
      ident = 1'b0;
      warm_left = '0;
      sx = '0; sy = '0; sz = '0; dx = '0; dy = '0;
      src_addr = '0; dst_addr = '0; src_base = '0; dst_base = '0;
      dx_lim = 8'd1; dy_lim = 8'd1; elem_bytes = 4'd1;
      addr_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SRC_X_STRIDE: x_step  = cfg_wdata;
          CFG_SRC_Y_STRIDE: y_step  = cfg_wdata;
          CFG_SRC_Z_STRIDE: z_step  = cfg_wdata;
          CFG_SRC_X_LIMIT:  x_lim   = cfg_wdata[7:0];
          CFG_SRC_Y_LIMIT:  y_lim   = cfg_wdata[7:0];
          CFG_SRC_Z_LIMIT:  z_lim   = cfg_wdata[7:0];
          CFG_DST_X_STRIDE: dx_step = cfg_wdata;
          CFG_DST_Y_STRIDE: dy_step = cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = out_data;
        if (addr_expect_q.size() == 0) begin
          errors++;
          if (reported < 10)
            $display("%0t: unexpected result v=%b st=%b sp=%b src=%h dst=%h busy=%b",
                     $realtime, got.out_valid, got.pool_start, got.pool_stop,
                     got.src_addr, got.dst_addr, got.busy_res);
          reported++;
        end else begin
          want = addr_expect_q.pop_front();
          if (got !== want) begin
            errors++;
            if (reported < 10)
              $display({"%0t: mismatch expected v=%b st=%b sp=%b src=%h dst=%h busy=%b",
                        " got v=%b st=%b sp=%b src=%h dst=%h busy=%b"},
                       $realtime, want.out_valid, want.pool_start, want.pool_stop,
                       want.src_addr, want.dst_addr, want.busy_res,
                       got.out_valid, got.pool_start, got.pool_stop,
                       got.src_addr, got.dst_addr, got.busy_res);
            reported++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_START) begin
          // drop a start while an operation runs
          if (!running) begin
            running    = 1'b1;
            warm_left  = WARM_LOAD;
            ident      = in_data.pool_ident;
            elem_bytes = in_data.elem_size;
            src_base   = in_data.src_base;
            dst_base   = in_data.dst_base;
            src_addr   = in_data.src_base;
            dst_addr   = in_data.dst_base;
            dx_lim     = in_data.dst_x_extent;
            dy_lim     = in_data.dst_y_extent;
            win_start  = 1'b1;
            win_stop   = ident || ({1'b0, x_lim} + {1'b0, y_lim} == 9'd2);
            sx = '0; sy = '0; sz = '0; dx = '0; dy = '0;
          end
        end else if (running) begin
          if (warm_left != '0) begin
            warm_left = warm_left - 1'b1;
            if (warm_left == '0)
              addr_live = 1'b1;
          end else if (addr_live) begin
            sx = sx + 8'd1;
            if (sx >= x_lim) begin
              sx = '0;
              sy = sy + 8'd1;
            end
            if (sy >= y_lim) begin
              sy = '0;
              sz = sz + 8'd1;
            end
            if (sz >= z_lim)
              sz = '0;

            wend = ({1'b0, sx} + 9'd1 == {1'b0, x_lim}) &&
                   ({1'b0, sy} + 9'd1 == {1'b0, y_lim}) &&
                   ({1'b0, sz} + 9'd1 == {1'b0, z_lim});

            if (ident || wend) begin
              dx = dx + 8'd1;
              if (dx >= dx_lim) begin
                dx = '0;
                dy = dy + 8'd1;
              end
            end

            prev_stop = win_stop;
            win_start = ident ? 1'b1 : prev_stop;
            win_stop  = ident ? 1'b1 : wend;

            if (dy >= dy_lim) begin
              dy        = '0;
              addr_live = 1'b0;
              running   = 1'b0;
            end

            px = 32'(sx); py = 32'(sy); pz = 32'(sz); pdx = 32'(dx); pdy = 32'(dy);
            kx = 32'(x_step); ky = 32'(y_step); kz = 32'(z_step);
            kdx = 32'(dx_step); kdy = 32'(dy_step);
            pe = 32'(elem_bytes);
            if (addr_live)
              src_addr = src_base + (pz * kz + py * ky + px * kx) * pe;
            if (win_start)
              dst_addr = dst_base + (pdy * kdy + pdx * kdx) * pe;
          end
        end
        want.out_valid  = addr_live;
        want.pool_start = win_start;
        want.pool_stop  = win_stop;
        want.src_addr   = src_addr;
        want.dst_addr   = dst_addr;
        want.busy_res   = running;
        addr_expect_q.push_back(want);
      end
    end
    pending     = addr_expect_q.size();
    pool_active = running;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool address sequencer testbench
// Drives start and tick requests through valid/ready with random gaps and
// stalls, reprograms strides and limits between operations, and leaves all
// result checking to the address checker instantiated beside the sequencer.
// ----------------------------------------------------------------------------
module testbench;
  import pas_pkg::*;

  localparam int WARMUP       = WARMUP_ROWS_DEF;
  localparam int RANDOM_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 16;
  localparam int TIMEOUT_NS   = 2000000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_req_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_res_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   errors;
  int   pending;
  logic pool_active;
  int   send_idle_pct = 8;
  int   recv_idle_pct = 84;
  logic hold_go       = 1'b0;
  int   items         = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pool_address_sequencer_top #(.WARMUP_ROWS(WARMUP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pas_addr_checker #(.WARMUP(WARMUP)) addr_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .pending     (pending),
    .pool_active (pool_active)
  );

  initial begin
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_req_t filler();
    in_req_t r;
    r.req_type     = REQ_TICK;
    r.src_base     = $urandom;
    r.dst_base     = $urandom;
    r.dst_x_extent = 8'($urandom_range(255));
    r.dst_y_extent = 8'($urandom_range(255));
    r.pool_ident   = 1'($urandom_range(1));
    r.elem_size    = 4'($urandom_range(15));
    return r;
  endfunction

  function automatic in_req_t start_req(logic id, logic [7:0] xe, logic [7:0] ye,
                                        logic [3:0] es, logic [31:0] sb,
                                        logic [31:0] db);
    in_req_t r;
    r.req_type     = REQ_START;
    r.src_base     = sb;
    r.dst_base     = db;
    r.dst_x_extent = xe;
    r.dst_y_extent = ye;
    r.pool_ident   = id;
    r.elem_size    = es;
    return r;
  endfunction

  // hold valid and payload until accepted; return at the following falling edge
  task automatic send(in_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(negedge clk);
  endtask

  task automatic load_config(cfg_t c);
    logic [7:0] junk;
    drain();
    junk = 8'($urandom_range(255));
    put_reg(CFG_SRC_X_STRIDE, c.src_x_stride);
    put_reg(CFG_SRC_Y_STRIDE, c.src_y_stride);
    put_reg(CFG_SRC_Z_STRIDE, c.src_z_stride);
    put_reg(CFG_SRC_X_LIMIT,  {junk, c.src_x_count_limit});
    put_reg(CFG_SRC_Y_LIMIT,  {~junk, c.src_y_count_limit});
    put_reg(CFG_SRC_Z_LIMIT,  {junk, c.src_z_count_limit});
    put_reg(CFG_DST_X_STRIDE, c.dst_x_stride);
    put_reg(CFG_DST_Y_STRIDE, c.dst_y_stride);
    cfg_we <= 1'b0;
  endtask

  // tick until the operation completes, with the odd ignored start mixed in
  task automatic finish_pool();
    in_req_t r;
    while (pool_active) begin
      r = filler();
      if ($urandom_range(99) < 4) begin
        r.req_type = REQ_START;
        send(r);
      end else begin
        send(r);
        items++;
      end
    end
    repeat ($urandom_range(2)) send(filler());
  endtask

  task automatic run_pool(in_req_t st);
    send(st);
    items++;
    if (!hold_go && items >= 400)
      hold_go = 1'b1;
    finish_pool();
  endtask

  task automatic run_phase(int kind);
    cfg_t       c;
    logic       id;
    logic [7:0] xe, ye;
    int         ops;
    c.src_x_stride = 16'($urandom);
    c.src_y_stride = 16'($urandom);
    c.src_z_stride = 16'($urandom);
    c.dst_x_stride = 16'($urandom);
    c.dst_y_stride = 16'($urandom);
    c.src_x_count_limit = 8'($urandom_range(1, 3));
    c.src_y_count_limit = 8'($urandom_range(1, 3));
    c.src_z_count_limit = 8'($urandom_range(1, 3));
    case (kind)
      0: begin
        c = '1;
        c.src_y_count_limit = 8'd1;
        c.src_z_count_limit = 8'd1;
      end
      1: begin
        c = '0;
        c.src_x_count_limit = 8'd1;
        c.src_y_count_limit = 8'd1;
        c.src_z_count_limit = 8'd255;
      end
      2: begin
        c.src_x_count_limit = 8'd1;
        c.src_y_count_limit = 8'd255;
        c.src_z_count_limit = 8'd1;
      end
      default: ;
    endcase
    load_config(c);
    ops = (kind < 3) ? 2 : int'($urandom_range(2, 3));
    for (int k = 0; k < ops; k++) begin
      if (items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 84;
      end else if (items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      id = (kind < 3) ? (k != 0) : 1'($urandom_range(1));
      if (id) begin
        xe = 8'($urandom_range(1, 8));
        ye = 8'($urandom_range(1, 8));
        if (kind == 0 || (kind > 2 && $urandom_range(19) == 0)) begin
          xe = 8'd255;
          ye = 8'd1;
        end else if (kind == 1 || (kind > 2 && $urandom_range(19) == 0)) begin
          xe = 8'd1;
          ye = 8'd255;
        end
      end else if (kind < 3) begin
        xe = 8'd1;
        ye = 8'd1;
      end else begin
        xe = 8'($urandom_range(1, 3));
        ye = 8'($urandom_range(1, 3));
      end
      run_pool(start_req(id, xe, ye, 4'($urandom_range(1, 8)), $urandom, $urandom));
    end
  endtask

  initial begin : stimulus
    int      phase;
    in_req_t r;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // tick while idle, then an identity run from all-ones base addresses, with an ignored start sent during it
    send(filler());
    send(start_req(1'b1, 8'd1, 8'd1, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    items++;
    r = start_req(1'b0, 8'd3, 8'd3, 4'd2, $urandom, $urandom);
    send(r);
    finish_pool();
    // windowed with unit window: stop asserted at start
    run_pool(start_req(1'b0, 8'd1, 8'd1, 4'd1, 32'h0, 32'h0));
    run_pool(start_req(1'b0, 8'd2, 8'd2, 4'd4, $urandom, $urandom));

    phase = 0;
    while (items < RANDOM_ITEMS) begin
      run_phase(phase < 3 ? phase : int'($urandom_range(15)));
      phase++;
    end

    drain();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* pool_address_sequencer_top.f */
sv/pas_pkg.sv
sv/pas_front.sv
sv/pas_engine.sv
sv/pool_address_sequencer_top.sv
dv/pas_addr_checker.sv
dv/testbench.sv
